// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the disk-bus interface glue.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define SASI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define SASI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/sasi_pkg.sv =====
// Package for the disk-bus interface glue: item, result and state types,
// port, action, line and control-bit constants. Depends on nothing.
`timescale 1ns / 1ps

package sasi_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_LINE  = 2'd2;

  localparam logic [7:0] PORT_DATA = 8'ha4;
  localparam logic [7:0] PORT_CTRL = 8'ha5;
  localparam logic [7:0] RD_NONE   = 8'hff;

  localparam logic [2:0] LN_BSY = 3'd0;
  localparam logic [2:0] LN_CXD = 3'd1;
  localparam logic [2:0] LN_IXO = 3'd2;
  localparam logic [2:0] LN_MSG = 3'd3;
  localparam logic [2:0] LN_REQ = 3'd4;
  localparam logic [2:0] LN_ACK = 3'd5;
  localparam logic [2:0] LN_TC  = 3'd6;

  localparam int CTL_SEL  = 5;
  localparam int CTL_RST  = 3;
  localparam int CTL_DMAE = 1;
  localparam int CTL_INTE = 0;

  localparam logic [5:0] NEG_RESET = 6'h3f;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] port;
    logic [7:0] data_in;
    logic [2:0] line_id;
    logic       line_level;
    logic [7:0] host_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       drq;
    logic       sel_out;
    logic       rst_out;
    logic       host_write;
    logic       host_read;
    logic [7:0] host_write_data;
  } result_t;

  typedef struct packed {
    logic [7:0] ctl;
    logic [5:0] neg;
    logic       irq;
    logic       drq;
  } state_t;

endpackage

// ===== rtl/sasi_step.sv =====
// Combinational step of the disk-bus interface glue: applies one item to
// the current state and forms the next state and the result. Uses sasi_pkg.
`timescale 1ns / 1ps

module sasi_step import sasi_pkg::*; (
  input  item_t   item,
  input  state_t  cur,
  output state_t  nxt,
  output result_t res
);

  logic drq_g_old;
  logic drq_g_new;
  logic irq_g_old;
  logic irq_g_new;

  function automatic logic drq_gate(input logic [5:0] neg);
    return !neg[LN_REQ] && neg[LN_CXD];
  endfunction

  function automatic logic irq_gate(input logic [5:0] neg, input logic [7:0] ctl);
    logic a;
    logic b;
    a = !(!neg[LN_REQ] && !neg[LN_IXO] && neg[LN_MSG] && !neg[LN_CXD]);
    b = !(!ctl[CTL_DMAE] && drq_gate(neg));
    return !(a && b);
  endfunction

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (item.action)
      ACT_WRITE: begin
        if (item.port == PORT_DATA) begin
          res.host_write      = 1'b1;
          res.host_write_data = item.data_in;
        end else if (item.port == PORT_CTRL) begin
          nxt.ctl = item.data_in;
        end
      end
      ACT_READ: begin
        if (item.port == PORT_DATA) begin
          res.host_read = 1'b1;
          res.read_data = item.host_data;
        end else if (item.port == PORT_CTRL) begin
          res.read_data = {~cur.neg[LN_REQ], 1'b0, ~cur.neg[LN_BSY], ~cur.neg[LN_MSG],
                           ~cur.neg[LN_CXD], ~cur.neg[LN_IXO], 1'b1, cur.irq};
        end else begin
          res.read_data = RD_NONE;
        end
      end
      ACT_LINE: begin
        if (item.line_id <= LN_ACK) begin
          nxt.neg[item.line_id] = ~item.line_level;
        end else if (item.line_id == LN_TC && item.line_level) begin
          nxt.ctl[CTL_DMAE] = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Latch update; with no change of lines or control no edge is seen.
    drq_g_old = drq_gate(cur.neg);
    drq_g_new = drq_gate(nxt.neg);
    irq_g_old = irq_gate(cur.neg, cur.ctl);
    irq_g_new = irq_gate(nxt.neg, nxt.ctl);
    if (!irq_g_old && irq_g_new) begin
      nxt.irq = nxt.ctl[CTL_INTE];
    end
    if (!drq_g_old && drq_g_new) begin
      nxt.drq = nxt.ctl[CTL_DMAE];
    end
    if (cur.ctl[CTL_INTE] && !nxt.ctl[CTL_INTE]) begin
      nxt.irq = 1'b0;
    end
    if (cur.ctl[CTL_DMAE] && !nxt.ctl[CTL_DMAE]) begin
      nxt.drq = 1'b0;
    end
    if (cur.neg[LN_ACK] && !nxt.neg[LN_ACK]) begin
      nxt.drq = 1'b0;
    end

    res.irq     = nxt.irq;
    res.drq     = nxt.drq;
    res.sel_out = nxt.ctl[CTL_SEL];
    res.rst_out = nxt.ctl[CTL_RST];
  end

endmodule

// ===== rtl/sasi_port_irq_drq_glue_top.sv =====
// Each item goes from input transfer to result through an input
// register and a result register. Throughput: one item per cycle while
// out_stall is low; state and result are a few gate levels in sasi_step.
// Reset (rst_n, synchronous, active low) clears control, IRQ and DRQ,
// marks all bus lines inactive and empties both registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sasi_port_irq_drq_glue_top import sasi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_port,
  input  logic [7:0] in_data_in,
  input  logic [2:0] in_line_id,
  input  logic       in_line_level,
  input  logic [7:0] in_host_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic       out_drq,
  output logic       out_sel_out,
  output logic       out_rst_out,
  output logic       out_host_write,
  output logic       out_host_read,
  output logic [7:0] out_host_write_data
);

  logic    in_vld_r;
  logic    in_vld_nxt;
  item_t   item_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    out_vld_r;
  logic    out_vld_nxt;
  logic    in_xfer;
  logic    adv;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  sasi_step u_step (
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      state_r.ctl <= '0;
      state_r.neg <= NEG_RESET;
      state_r.irq <= 1'b0;
      state_r.drq <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.action     <= in_action;
      item_r.port       <= in_port;
      item_r.data_in    <= in_data_in;
      item_r.line_id    <= in_line_id;
      item_r.line_level <= in_line_level;
      item_r.host_data  <= in_host_data;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_read_data       = res_r.read_data;
  assign out_irq             = res_r.irq;
  assign out_drq             = res_r.drq;
  assign out_sel_out         = res_r.sel_out;
  assign out_rst_out         = res_r.rst_out;
  assign out_host_write      = res_r.host_write;
  assign out_host_read       = res_r.host_read;
  assign out_host_write_data = res_r.host_write_data;

  `SASI_ASSERT_IMP(a_stall_holds_item, clk, rst_n, in_stall, in_vld_r, "stall without item")
  `SASI_ASSERT(a_strobes_excl, clk, rst_n,
    !(out_vld_r && res_r.host_write && res_r.host_read), "data strobes both set")
  `SASI_ASSERT_IMP(a_wdata_zero, clk, rst_n, out_vld_r && !res_r.host_write,
    res_r.host_write_data == 8'h00, "write data without write strobe")
  `SASI_ASSERT_IMP(a_state_on_adv, clk, rst_n, !$past(adv) && $past(rst_n),
    $stable(state_r), "state changed without a transfer")

endmodule

// ===== tb/tb_sasi_port_irq_drq_glue_top.sv =====
// Self-checking testbench for the disk-bus interface glue. It sends port accesses and
// bus line changes, predicts each result from a shadow copy of control, lines and latches,
// and checks every transfer on the result side. Depends on sasi_pkg and the top level.
`timescale 1ns / 1ps

module tb_sasi_port_irq_drq_glue_top;
  import sasi_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [2:0] LN_NONE  = 3'd7;

  localparam int ST_REQ = 7;
  localparam int ST_BSY = 5;
  localparam int ST_MSG = 4;
  localparam int ST_CXD = 3;
  localparam int ST_IXO = 2;
  localparam int ST_ONE = 1;
  localparam int ST_IRQ = 0;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = '0;
  logic [7:0] in_port = '0;
  logic [7:0] in_data_in = '0;
  logic [2:0] in_line_id = '0;
  logic       in_line_level = 1'b0;
  logic [7:0] in_host_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq;
  logic       out_drq;
  logic       out_sel_out;
  logic       out_rst_out;
  logic       out_host_write;
  logic       out_host_read;
  logic [7:0] out_host_write_data;

  logic [7:0] shadow_ctl = '0;
  logic [5:0] shadow_neg = NEG_RESET;
  logic       shadow_irq = 1'b0;
  logic       shadow_drq = 1'b0;

  result_t pending_results[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int err_count = 0;

  sasi_port_irq_drq_glue_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_port             (in_port),
    .in_data_in          (in_data_in),
    .in_line_id          (in_line_id),
    .in_line_level       (in_line_level),
    .in_host_data        (in_host_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_irq             (out_irq),
    .out_drq             (out_drq),
    .out_sel_out         (out_sel_out),
    .out_rst_out         (out_rst_out),
    .out_host_write      (out_host_write),
    .out_host_read       (out_host_read),
    .out_host_write_data (out_host_write_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic drq_gate_on(input logic [5:0] neg);
    return !neg[LN_REQ] && neg[LN_CXD];
  endfunction

  function automatic logic irq_gate_on(input logic [5:0] neg, input logic [7:0] ctl);
    logic phase_hit;
    phase_hit = !neg[LN_REQ] && !neg[LN_IXO] && neg[LN_MSG] && !neg[LN_CXD];
    return phase_hit || (!ctl[CTL_DMAE] && drq_gate_on(neg));
  endfunction

  function automatic void settle_latches(input logic [5:0] old_neg, input logic [7:0] old_ctl);
    if (!irq_gate_on(old_neg, old_ctl) && irq_gate_on(shadow_neg, shadow_ctl))
      shadow_irq = shadow_ctl[CTL_INTE];
    if (!drq_gate_on(old_neg) && drq_gate_on(shadow_neg))
      shadow_drq = shadow_ctl[CTL_DMAE];
    if (old_ctl[CTL_INTE] && !shadow_ctl[CTL_INTE])
      shadow_irq = 1'b0;
    if (old_ctl[CTL_DMAE] && !shadow_ctl[CTL_DMAE])
      shadow_drq = 1'b0;
    if (old_neg[LN_ACK] && !shadow_neg[LN_ACK])
      shadow_drq = 1'b0;
  endfunction

  function automatic result_t next_result(input item_t it);
    result_t    r;
    logic [7:0] old_ctl;
    logic [5:0] old_neg;
    r = '0;
    old_ctl = shadow_ctl;
    old_neg = shadow_neg;
    case (it.action)
      ACT_WRITE: begin
        if (it.port == PORT_DATA) begin
          r.host_write = 1'b1;
          r.host_write_data = it.data_in;
        end else if (it.port == PORT_CTRL) begin
          shadow_ctl = it.data_in;
          settle_latches(old_neg, old_ctl);
        end
      end
      ACT_READ: begin
        if (it.port == PORT_DATA) begin
          r.host_read = 1'b1;
          r.read_data = it.host_data;
        end else if (it.port == PORT_CTRL) begin
          r.read_data[ST_REQ] = !shadow_neg[LN_REQ];
          r.read_data[ST_BSY] = !shadow_neg[LN_BSY];
          r.read_data[ST_MSG] = !shadow_neg[LN_MSG];
          r.read_data[ST_CXD] = !shadow_neg[LN_CXD];
          r.read_data[ST_IXO] = !shadow_neg[LN_IXO];
          r.read_data[ST_ONE] = 1'b1;
          r.read_data[ST_IRQ] = shadow_irq;
        end else begin
          r.read_data = RD_NONE;
        end
      end
      ACT_LINE: begin
        if (it.line_id <= LN_ACK) begin
          shadow_neg[it.line_id] = !it.line_level;
          settle_latches(old_neg, old_ctl);
        end else if (it.line_id == LN_TC && it.line_level) begin
          shadow_ctl[CTL_DMAE] = 1'b0;
          settle_latches(old_neg, old_ctl);
        end
      end
      default: ;
    endcase
    r.irq = shadow_irq;
    r.drq = shadow_drq;
    r.sel_out = shadow_ctl[CTL_SEL];
    r.rst_out = shadow_ctl[CTL_RST];
    return r;
  endfunction

  task automatic send_item(input item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_action <= it.action;
    in_port <= it.port;
    in_data_in <= it.data_in;
    in_line_id <= it.line_id;
    in_line_level <= it.line_level;
    in_host_data <= it.host_data;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(next_result(it));
  endtask

  task automatic send_fields(input logic [1:0] action, input logic [7:0] port,
                             input logic [7:0] data, input logic [2:0] line_id,
                             input logic level, input logic [7:0] hdata);
    item_t it;
    it.action = action;
    it.port = port;
    it.data_in = data;
    it.line_id = line_id;
    it.line_level = level;
    it.host_data = hdata;
    send_item(it);
  endtask

  function automatic item_t random_access();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      it.action = ACT_LINE;
    else if (pick < 60)
      it.action = ACT_WRITE;
    else if (pick < 94)
      it.action = ACT_READ;
    else
      it.action = ACT_NONE;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      it.port = PORT_CTRL;
    else if (pick < 80)
      it.port = PORT_DATA;
    else
      it.port = 8'($urandom_range(0, 255));
    it.data_in = 8'($urandom_range(0, 255));
    it.line_id = 3'($urandom_range(0, 7));
    it.line_level = 1'($urandom_range(0, 1));
    it.host_data = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_item(random_access());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_bit(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, read_data %02h", $time, out_read_data);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, out_read_data);
        check_bit("irq", want.irq, out_irq);
        check_bit("drq", want.drq, out_drq);
        check_bit("sel_out", want.sel_out, out_sel_out);
        check_bit("rst_out", want.rst_out, out_rst_out);
        check_bit("host_write", want.host_write, out_host_write);
        check_bit("host_read", want.host_read, out_host_read);
        check_field("host_write_data", want.host_write_data, out_host_write_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_fields(ACT_READ, PORT_CTRL, 8'h00, LN_BSY, 1'b0, 8'h00);
    send_fields(ACT_READ, PORT_DATA, 8'h00, LN_BSY, 1'b0, 8'hff);
    send_fields(ACT_READ, PORT_DATA, 8'hff, LN_BSY, 1'b1, 8'h00);
    send_fields(ACT_READ, 8'h00, 8'h00, LN_BSY, 1'b0, 8'h5a);
    send_fields(ACT_WRITE, 8'hff, 8'hff, LN_BSY, 1'b0, 8'h00);
    send_fields(ACT_WRITE, PORT_DATA, 8'hff, LN_BSY, 1'b0, 8'h00);
    send_fields(ACT_WRITE, PORT_DATA, 8'h00, LN_BSY, 1'b0, 8'hff);
    send_fields(ACT_WRITE, PORT_CTRL, 8'hff, LN_BSY, 1'b0, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_IXO, 1'b1, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_CXD, 1'b1, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_REQ, 1'b1, 8'h00);
    send_fields(ACT_READ, PORT_CTRL, 8'h00, LN_BSY, 1'b0, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_CXD, 1'b0, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_ACK, 1'b1, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_ACK, 1'b0, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_CXD, 1'b1, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_CXD, 1'b0, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_TC, 1'b0, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_TC, 1'b1, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'hff, LN_NONE, 1'b1, 8'hff);
    send_fields(ACT_NONE, PORT_CTRL, 8'h00, LN_ACK, 1'b1, 8'hff);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_BSY, 1'b1, 8'h00);
    send_fields(ACT_LINE, PORT_CTRL, 8'h00, LN_MSG, 1'b1, 8'h00);
    send_fields(ACT_READ, PORT_CTRL, 8'h00, LN_BSY, 1'b0, 8'h00);
    send_fields(ACT_WRITE, PORT_CTRL, 8'h00, LN_BSY, 1'b0, 8'h00);
  endtask

  task automatic test_no_idle();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_random(350);
  endtask

  task automatic test_sender_idle();
    src_idle_pct = 81;
    sink_stall_pct = 0;
    run_random(250);
  endtask

  task automatic test_receiver_stall();
    src_idle_pct = 0;
    sink_stall_pct = 81;
    run_random(250);
  endtask

  task automatic test_both_idle();
    src_idle_pct = 21;
    sink_stall_pct = 21;
    run_random(250);
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    run_random(40);
  endtask

  task automatic test_drain_pause();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_random(30);
    wait_drained();
    run_random(30);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sasi_pkg.sv
rtl/sasi_step.sv
rtl/sasi_port_irq_drq_glue_top.sv
tb/tb_sasi_port_irq_drq_glue_top.sv
